@@ rtl/pcpd_pkg.sv @@
package pcpd_pkg;

  localparam int unsigned CodeW         = 5;
  localparam int unsigned LenW          = 3;
  localparam int unsigned ColorW        = 8;
  localparam int unsigned MaxCodeBits   = 5;
  localparam int unsigned DefTableDepth = 32;

  typedef enum logic {
    CmdLoad   = 1'b0,
    CmdDecode = 1'b1
  } pcpd_cmd_e;

  typedef enum logic [1:0] {
    StatPixel   = 2'd0,
    StatNoMatch = 2'd1,
    StatFull    = 2'd2
  } pcpd_status_e;

  typedef enum logic [1:0] {
    StateClear,
    StateIdle,
    StateLook,
    StateCheck
  } pcpd_state_e;

  typedef struct packed {
    pcpd_cmd_e         cmd;
    logic [CodeW-1:0]  code_value;
    logic [LenW-1:0]   code_len;
    logic [ColorW-1:0] red_in;
    logic [ColorW-1:0] green_in;
    logic [ColorW-1:0] blue_in;
    logic              code_bit;
  } pcpd_in_t;

  typedef struct packed {
    pcpd_status_e      status;
    logic [ColorW-1:0] red_out;
    logic [ColorW-1:0] green_out;
    logic [ColorW-1:0] blue_out;
  } pcpd_out_t;

  function automatic logic [CodeW-1:0] low_mask(input logic [LenW-1:0] len);
    logic [CodeW-1:0] m;
    for (int i = 0; i < CodeW; i++) begin
      m[i] = (i < int'(len));
    end
    return m;
  endfunction

endpackage

@@ rtl/pcpd_stream_if.sv @@
interface pcpd_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/pcpd_ram.sv @@
module pcpd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

@@ rtl/prefix_code_palette_decoder.sv @@
// Prefix-code palette decoder. Load beats append a (code, length, color) entry to a table of
// TableDepth entries; decode beats shift one stream bit into the partial code, and the first
// loaded entry whose code and length match yields a pixel beat. Five bits with no match give
// a no-match beat, and a load into a full table gives a table-full beat. Each input beat passes
// through a read of the lookup memory (addressed by partial length and code), a read of the
// entry memory at the index found there to confirm it, and a final step to decide and write
// back; no new beat is taken before that. A result beat waits in an output register; the block
// holds in its final step only if a new result finds that register still occupied. After reset
// the lookup memory's 160 entries (MaxCodeBits << CodeW) clear one a cycle; input waits till then.
module prefix_code_palette_decoder #(
  parameter int unsigned TableDepth = pcpd_pkg::DefTableDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  pcpd_stream_if.sink   in_i,
  pcpd_stream_if.source out_o
);

  localparam int unsigned IdxW    = $clog2(TableDepth);
  localparam int unsigned CntW    = $clog2(TableDepth + 1);
  localparam int unsigned LkLenW  = $clog2(pcpd_pkg::MaxCodeBits);
  localparam int unsigned LkAw    = LkLenW + pcpd_pkg::CodeW;
  localparam int unsigned LkDepth = pcpd_pkg::MaxCodeBits << pcpd_pkg::CodeW;
  localparam int unsigned RgbW    = 3 * pcpd_pkg::ColorW;
  localparam int unsigned LkW     = IdxW + RgbW;
  localparam int unsigned EntW    = 1 + LkAw;

  pcpd_pkg::pcpd_state_e state_q, state_d;

  logic [CntW-1:0]              cnt_q, cnt_d;
  logic [pcpd_pkg::CodeW-1:0]   pcode_q, pcode_d;
  logic [pcpd_pkg::LenW-1:0]    plen_q, plen_d;
  logic [LkAw-1:0]              clr_q, clr_d;
  pcpd_pkg::pcpd_cmd_e          cmd_q;
  logic [LkAw-1:0]              addr_q;
  logic                         lvld_q;
  logic [RgbW-1:0]              rgb_q;
  logic                         out_valid_q, out_valid_d;
  pcpd_pkg::pcpd_out_t          out_data_q, out_data_d;

  logic                         accept;
  logic [LkAw-1:0]              in_addr;
  logic                         in_lvld;
  logic [pcpd_pkg::LenW-1:0]    lenm1;

  logic                         lk_we;
  logic [LkW-1:0]               lk_wdata;
  logic [LkW-1:0]               lk_rdata;
  logic                         clr_we;
  logic                         clr_done;
  logic                         ent_we;
  logic                         ent_re;
  logic [EntW-1:0]              ent_rdata;

  logic [IdxW-1:0]              lk_idx;
  logic                         hit;
  logic                         full;
  logic [pcpd_pkg::LenW-1:0]    nlen;
  logic                         need_res;
  logic                         out_free;
  logic                         go;

  assign accept = in_i.valid && in_i.ready;
  assign lenm1  = in_i.data.code_len - pcpd_pkg::LenW'(1);

  always_comb begin
    if (in_i.data.cmd == pcpd_pkg::CmdLoad) begin
      in_addr = {LkLenW'(lenm1), in_i.data.code_value & pcpd_pkg::low_mask(in_i.data.code_len)};
      in_lvld = (in_i.data.code_len != '0) &&
                (in_i.data.code_len <= pcpd_pkg::LenW'(pcpd_pkg::MaxCodeBits));
    end else begin
      in_addr = {LkLenW'(plen_q), pcode_q[pcpd_pkg::CodeW-2:0], in_i.data.code_bit};
      in_lvld = 1'b1;
    end
  end

  assign clr_we   = (state_q == pcpd_pkg::StateClear);
  assign clr_done = (clr_q == LkAw'(LkDepth - 1));

  assign lk_idx   = lk_rdata[LkW-1:RgbW];
  assign full     = (cnt_q == CntW'(TableDepth));
  assign nlen     = plen_q + pcpd_pkg::LenW'(1);
  assign hit      = lvld_q && (CntW'(lk_idx) < cnt_q) && ent_rdata[EntW-1] &&
                    (ent_rdata[LkAw-1:0] == addr_q);
  assign need_res = (cmd_q == pcpd_pkg::CmdLoad) ? full :
                    (hit || (nlen == pcpd_pkg::LenW'(pcpd_pkg::MaxCodeBits)));
  assign out_free = !out_valid_q || out_o.ready;
  assign go       = !need_res || out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pcpd_pkg::StateClear: if (clr_done) state_d = pcpd_pkg::StateIdle;
      pcpd_pkg::StateIdle:  if (accept) state_d = pcpd_pkg::StateLook;
      pcpd_pkg::StateLook:  state_d = pcpd_pkg::StateCheck;
      pcpd_pkg::StateCheck: if (go) state_d = pcpd_pkg::StateIdle;
      default:              state_d = pcpd_pkg::StateIdle;
    endcase
  end

  always_comb begin
    in_i.ready  = 1'b0;
    ent_re      = 1'b0;
    ent_we      = 1'b0;
    lk_we       = 1'b0;
    lk_wdata    = {cnt_q[IdxW-1:0], rgb_q};
    clr_d       = clr_q;
    cnt_d       = cnt_q;
    pcode_d     = pcode_q;
    plen_d      = plen_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_data_d  = out_data_q;
    unique case (state_q)
      pcpd_pkg::StateClear: clr_d = clr_q + LkAw'(1);
      pcpd_pkg::StateIdle: in_i.ready = 1'b1;
      pcpd_pkg::StateLook: ent_re = 1'b1;
      pcpd_pkg::StateCheck: begin
        if (go) begin
          if (cmd_q == pcpd_pkg::CmdLoad) begin
            if (full) begin
              out_valid_d = 1'b1;
              out_data_d  = '{status: pcpd_pkg::StatFull, default: '0};
            end else begin
              ent_we = 1'b1;
              lk_we  = lvld_q && !hit;
              cnt_d  = cnt_q + CntW'(1);
            end
          end else if (hit) begin
            out_valid_d = 1'b1;
            out_data_d  = '{status: pcpd_pkg::StatPixel,
                            red_out: lk_rdata[RgbW-1:2*pcpd_pkg::ColorW],
                            green_out: lk_rdata[2*pcpd_pkg::ColorW-1:pcpd_pkg::ColorW],
                            blue_out: lk_rdata[pcpd_pkg::ColorW-1:0]};
            pcode_d     = '0;
            plen_d      = '0;
          end else if (nlen == pcpd_pkg::LenW'(pcpd_pkg::MaxCodeBits)) begin
            out_valid_d = 1'b1;
            out_data_d  = '{status: pcpd_pkg::StatNoMatch, default: '0};
            pcode_d     = '0;
            plen_d      = '0;
          end else begin
            pcode_d = addr_q[pcpd_pkg::CodeW-1:0];
            plen_d  = nlen;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pcpd_pkg::StateClear;
      clr_q       <= '0;
      cnt_q       <= '0;
      pcode_q     <= '0;
      plen_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cnt_q       <= cnt_d;
      pcode_q     <= pcode_d;
      plen_q      <= plen_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    if (accept) begin
      cmd_q  <= in_i.data.cmd;
      addr_q <= in_addr;
      lvld_q <= in_lvld;
      rgb_q  <= {in_i.data.red_in, in_i.data.green_in, in_i.data.blue_in};
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  pcpd_ram #(
    .Width (LkW),
    .Depth (LkDepth)
  ) u_lookup_ram (
    .clk_i   (clk_i),
    .we_i    (lk_we || clr_we),
    .waddr_i (clr_we ? clr_q : addr_q),
    .wdata_i (clr_we ? {LkW{1'b0}} : lk_wdata),
    .re_i    (accept),
    .raddr_i (in_addr),
    .rdata_o (lk_rdata)
  );

  pcpd_ram #(
    .Width (EntW),
    .Depth (TableDepth)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (cnt_q[IdxW-1:0]),
    .wdata_i ({lvld_q, addr_q}),
    .re_i    (ent_re),
    .raddr_i (lk_idx),
    .rdata_o (ent_rdata)
  );

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(TableDepth))
    else $error("entry count beyond table depth");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == $past(cnt_q)) || (cnt_q == $past(cnt_q) + CntW'(1)))
    else $error("entry count moved by more than one");

  a_plen_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    plen_q < pcpd_pkg::LenW'(pcpd_pkg::MaxCodeBits))
    else $error("partial code not cleared at its limit");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=> ($stable(out_data_q) && out_valid_q))
    else $error("pending result lost");

  a_write_in_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ent_we || lk_we) |-> (state_q == pcpd_pkg::StateCheck && cmd_q == pcpd_pkg::CmdLoad))
    else $error("memory write outside a load");

endmodule
